>>> sv/shq_pkg.sv
// ----------------------------------------------------------------------------
// shq_pkg
// Shared types and constants for the suspend handshake controller with its
// event queue.
// ----------------------------------------------------------------------------
package shq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [7:0]  COUNTDOWN_RESET = 8'd5;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUSPEND_REQ = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STANDBY_REQ = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACK         = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP         = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd5;

  localparam logic REG_COUNTDOWN = 1'b0;
  localparam logic REG_LISTENER  = 1'b1;

  localparam logic [1:0] KIND_FW_SUSPEND   = 2'd0;
  localparam logic [1:0] KIND_USER_SUSPEND = 2'd1;
  localparam logic [1:0] KIND_RESUME       = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_LISTEN = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SUSPEND_REQ,
    OP_STANDBY_REQ,
    OP_ACK,
    OP_POP,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        power_event;
    logic [31:0] now_seconds;
    logic        notify_refused;
    logic        query_refused;
  } item_t;

  typedef struct packed {
    logic        phase;
    logic        signal_listener;
    logic        enter_standby;
    logic        enter_suspend;
    logic [31:0] event_stamp;
    logic [31:0] event_sequence;
    logic [1:0]  event_kind;
    logic        event_valid;
    logic [1:0]  status;
  } result_t;

endpackage

>>> sv/suspend_handshake_with_event_queue_core.sv
// ----------------------------------------------------------------------------
// suspend_handshake_with_event_queue_core
// Suspend handshake controller with a small event ring: command decode,
// a two-entry item queue, and the execution back end; APB register port.
// ----------------------------------------------------------------------------
// path: a command is written into the two-entry queue, and the back end then
// registers its reply into m_tdata and raises m_tvalid
// throughput: one command per cycle while the reply side keeps taking results
// the two-entry queue and output register let each side stall on its own
// reset: synchronous, clears control state; countdown_default returns to 5,
// listener_present to 0; event ring contents stay undefined until written
module suspend_handshake_with_event_queue_core
  import shq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // power_event[0], now_seconds[32:1], notify_refused[33], query_refused[34]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[2:0]
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[1:0], event_valid[2], event_kind[4:3], event_sequence[36:5],
  // event_stamp[68:37], enter_suspend[69], enter_standby[70],
  // signal_listener[71], phase[72]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [7:0] countdown_default;
  logic       listener_present;
  logic       cfg_wr;

  item_t   front_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown_default <= COUNTDOWN_RESET;
      listener_present  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COUNTDOWN: countdown_default <= pwdata[7:0];
        REG_LISTENER:  listener_present  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUNTDOWN: prdata = {24'd0, countdown_default};
      REG_LISTENER:  prdata = {31'd0, listener_present};
      default:       prdata = '0;
    endcase
  end

  shq_front u_front (
    .cmd  (s_tuser),
    .data (s_tdata),
    .item (front_item)
  );

  shq_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_tvalid),
    .wr_ready (s_tready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  shq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .countdown_default (countdown_default),
    .listener_present  (listener_present),
    .in_valid          (q_valid),
    .in_ready          (q_ready),
    .in_item           (q_item),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_result        (result)
  );

  assign m_tdata = {7'd0, result};

endmodule

>>> sv/shq_front.sv
// ----------------------------------------------------------------------------
// shq_front
// Command decode: turns the raw command code and tick fields into a
// classified work item for the back end.
// ----------------------------------------------------------------------------
module shq_front
  import shq_pkg::*;
(
  input  logic [CMD_W-1:0]     cmd,
  input  logic [IN_DATA_W-1:0] data,
  output item_t                item
);

  op_t op;

  always_comb begin
    unique case (cmd)
      CMD_TICK:        op = OP_TICK;
      CMD_SUSPEND_REQ: op = OP_SUSPEND_REQ;
      CMD_STANDBY_REQ: op = OP_STANDBY_REQ;
      CMD_ACK:         op = OP_ACK;
      CMD_POP:         op = OP_POP;
      CMD_CLEAR:       op = OP_CLEAR;
      default:         op = OP_NOP;
    endcase
  end

  always_comb begin
    item.op             = op;
    item.power_event    = data[0];
    item.now_seconds    = data[32:1];
    item.notify_refused = data[33];
    item.query_refused  = data[34];
  end

endmodule

>>> sv/shq_fifo.sv
// ----------------------------------------------------------------------------
// shq_fifo
// Two-entry queue of decoded items between the front and the back end.
// ----------------------------------------------------------------------------
module shq_fifo
  import shq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count above two");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("pointers disagree with count");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !rd_ready) |=> count == 2'd2)
    else $error("full queue lost an entry");

endmodule

>>> sv/shq_back.sv
// ----------------------------------------------------------------------------
// shq_back
// Executes decoded items: suspend countdown and handshake, standby, event
// ring with sequence numbers, and the registered result.
// ----------------------------------------------------------------------------
module shq_back
  import shq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] countdown_default,
  input  logic       listener_present,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_result
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [1:0]  kind_mem  [QUEUE_DEPTH];
  logic [31:0] seq_mem   [QUEUE_DEPTH];
  logic [31:0] stamp_mem [QUEUE_DEPTH];

  logic             phase_reg, phase_reg_next;
  logic [7:0]       countdown, countdown_next;
  logic             user_pending, user_pending_next;
  logic             acked, acked_next;
  logic             standby_pending, standby_pending_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [31:0]      seq_ctr, seq_ctr_next;

  logic             wa_en, wb_en;
  logic [IDX_W-1:0] wa_slot, wb_slot;
  logic [1:0]       wa_kind;
  logic [31:0]      wa_seq, wb_seq;

  logic    take;
  result_t res;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(i) + SUM_W'(c);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    logic       finished;
    logic       try_s;
    logic       have;
    logic [1:0] kind;
    phase_reg_next       = phase_reg;
    countdown_next       = countdown;
    user_pending_next    = user_pending;
    acked_next           = acked;
    standby_pending_next = standby_pending;
    head_next            = head;
    count_next           = count;
    seq_ctr_next         = seq_ctr;
    wa_en   = 1'b0;
    wa_slot = '0;
    wa_kind = KIND_FW_SUSPEND;
    wa_seq  = '0;
    wb_en   = 1'b0;
    wb_slot = '0;
    wb_seq  = '0;
    res     = '0;
    finished = 1'b0;
    try_s    = 1'b0;
    have     = in_item.power_event || user_pending;
    kind     = in_item.power_event ? KIND_FW_SUSPEND : KIND_USER_SUSPEND;
    case (in_item.op)
      OP_TICK: begin
        if (!phase_reg_next) begin
          if (countdown == 8'd0) begin
            if (have) begin
              if (countdown_default != 8'd0) begin
                acked_next     = 1'b0;
                countdown_next = countdown_default;
              end else begin
                acked_next = 1'b1;
              end
              if (listener_present) begin
                if (count_next < CNT_W'(QUEUE_DEPTH)) begin
                  wa_slot    = idx_add(head_next, count_next);
                  count_next = count_next + CNT_W'(1);
                end else begin
                  wa_slot   = head_next;
                  head_next = idx_inc(head_next);
                end
                seq_ctr_next        = seq_ctr_next + 32'd1;
                wa_en               = 1'b1;
                wa_kind             = kind;
                wa_seq              = seq_ctr_next;
                res.signal_listener = 1'b1;
              end
              try_s = acked_next;
            end
          end else begin
            countdown_next = countdown - 8'd1;
            if (countdown_next == 8'd0) begin
              acked_next = 1'b1;
            end
            try_s = acked_next;
          end
          if (try_s) begin
            if (in_item.notify_refused) begin
              phase_reg_next = 1'b0;
              finished       = 1'b1;
            end else begin
              phase_reg_next = 1'b1;
            end
          end
        end
        if (!finished && phase_reg_next) begin
          if (in_item.query_refused) begin
            finished = 1'b1;
          end else begin
            res.enter_suspend = 1'b1;
            if (listener_present) begin
              if (count_next < CNT_W'(QUEUE_DEPTH)) begin
                wb_slot    = idx_add(head_next, count_next);
                count_next = count_next + CNT_W'(1);
              end else begin
                wb_slot   = head_next;
                head_next = idx_inc(head_next);
              end
              seq_ctr_next        = seq_ctr_next + 32'd1;
              wb_en               = 1'b1;
              wb_seq              = seq_ctr_next;
              res.signal_listener = 1'b1;
            end
            user_pending_next = 1'b0;
            acked_next        = 1'b0;
            countdown_next    = 8'd0;
            phase_reg_next    = 1'b0;
          end
        end
        if (!finished && standby_pending) begin
          standby_pending_next = 1'b0;
          res.enter_standby    = 1'b1;
        end
      end
      OP_SUSPEND_REQ: begin
        acked_next        = 1'b0;
        user_pending_next = 1'b1;
      end
      OP_STANDBY_REQ: begin
        standby_pending_next = 1'b1;
      end
      OP_ACK: begin
        if (countdown != 8'd0 || user_pending) begin
          acked_next = 1'b1;
        end
      end
      OP_POP: begin
        if (!listener_present) begin
          res.status = STATUS_NO_LISTEN;
        end else if (count == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.event_valid = 1'b1;
          head_next       = idx_inc(head);
          count_next      = count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
        head_next  = '0;
      end
      default: begin
      end
    endcase
    res.phase = phase_reg_next;
  end

  always_ff @(posedge clk) begin
    if (take && wa_en && !(wb_en && wb_slot == wa_slot)) begin
      kind_mem[wa_slot]  <= wa_kind;
      seq_mem[wa_slot]   <= wa_seq;
      stamp_mem[wa_slot] <= in_item.now_seconds;
    end
    if (take && wb_en) begin
      kind_mem[wb_slot]  <= KIND_RESUME;
      seq_mem[wb_slot]   <= wb_seq;
      stamp_mem[wb_slot] <= in_item.now_seconds;
    end
  end

  // popped entry is read from the ring straight into the result register
  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= '{
        phase:           res.phase,
        signal_listener: res.signal_listener,
        enter_standby:   res.enter_standby,
        enter_suspend:   res.enter_suspend,
        event_stamp:     res.event_valid ? stamp_mem[head] : 32'd0,
        event_sequence:  res.event_valid ? seq_mem[head] : 32'd0,
        event_kind:      res.event_valid ? kind_mem[head] : KIND_FW_SUSPEND,
        event_valid:     res.event_valid,
        status:          res.status
      };
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= 1'b0;
      countdown       <= 8'd0;
      user_pending    <= 1'b0;
      acked           <= 1'b0;
      standby_pending <= 1'b0;
      head            <= '0;
      count           <= '0;
      seq_ctr         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase_reg       <= phase_reg_next;
        countdown       <= countdown_next;
        user_pending    <= user_pending_next;
        acked           <= acked_next;
        standby_pending <= standby_pending_next;
        head            <= head_next;
        count           <= count_next;
        seq_ctr         <= seq_ctr_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("event ring count above depth");
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= IDX_W'(QUEUE_DEPTH - 1))
    else $error("event ring head out of range");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (take && in_item.op == OP_CLEAR) |=> (count == '0 && head == '0))
    else $error("clear left entries in ring");
  a_suspend_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.enter_suspend) |-> !out_result.phase)
    else $error("suspend issued while still awaiting query");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.event_valid) |-> out_result.status == STATUS_OK)
    else $error("event returned with error status");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the suspend handshake controller with its event
// ring. Commands are streamed in with random gaps while replies are drained
// with random stalls. A cycle-free model predicts every reply and each
// transaction is checked field by field. Register settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import shq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RING = QUEUE_DEPTH_DEF;
  localparam int RES_W = $bits(result_t);

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic             power;
    logic [31:0]      now;
    logic             nref;
    logic             qref;
  } ctl_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  suspend_handshake_with_event_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  logic [7:0]  cd_reload = COUNTDOWN_RESET;
  logic        listening = 1'b0;
  logic        awaiting_query = 1'b0;
  logic [7:0]  ticks_left = '0;
  logic        user_req = 1'b0;
  logic        acked = 1'b0;
  logic        standby_req = 1'b0;
  logic [1:0]  ring_kind [RING];
  logic [31:0] ring_seq [RING];
  logic [31:0] ring_stamp [RING];
  int          ring_head = 0;
  int          ring_count = 0;
  logic [31:0] seq_num = '0;

  ctl_cmd_t cmd_backlog [$];
  result_t  ctl_replies [$];
  int       queued = 0;
  int       in_taken = 0;
  int       in_marked = 0;
  int       in_gap = 0;
  int       replies_seen = 0;
  int       stall_left = 0;
  bit       long_hold_done = 1'b0;
  bit       idle_on = 1'b1;
  int       mismatches = 0;

  function automatic bit log_event(input logic [1:0] kind, input logic [31:0] stamp);
    int slot;
    if (!listening) return 1'b0;
    if (ring_count < RING) begin
      slot = (ring_head + ring_count) % RING;
      ring_count++;
    end else begin
      slot = ring_head;
      ring_head = (ring_head + 1) % RING;
    end
    seq_num = seq_num + 32'd1;
    ring_kind[slot] = kind;
    ring_seq[slot] = seq_num;
    ring_stamp[slot] = stamp;
    return 1'b1;
  endfunction

  function automatic result_t apply_ctl_cmd(input ctl_cmd_t c);
    result_t    r;
    logic       done;
    logic       try_susp;
    logic       have;
    logic [1:0] kind;
    r = '0;
    case (c.cmd)
      CMD_TICK: begin
        done = 1'b0;
        try_susp = 1'b0;
        if (!awaiting_query) begin
          if (ticks_left == 0) begin
            have = 1'b1;
            kind = KIND_FW_SUSPEND;
            if (c.power) kind = KIND_FW_SUSPEND;
            else if (user_req) kind = KIND_USER_SUSPEND;
            else have = 1'b0;
            if (have) begin
              if (cd_reload != 0) begin
                acked = 1'b0;
                ticks_left = cd_reload;
              end else begin
                acked = 1'b1;
              end
              if (log_event(kind, c.now)) r.signal_listener = 1'b1;
              try_susp = acked;
            end
          end else begin
            ticks_left = ticks_left - 8'd1;
            if (ticks_left == 0) acked = 1'b1;
            try_susp = acked;
          end
          if (try_susp) begin
            if (c.nref) begin
              awaiting_query = 1'b0;
              done = 1'b1;
            end else begin
              awaiting_query = 1'b1;
            end
          end
        end
        if (!done && awaiting_query) begin
          if (c.qref) begin
            done = 1'b1;
          end else begin
            r.enter_suspend = 1'b1;
            if (log_event(KIND_RESUME, c.now)) r.signal_listener = 1'b1;
            user_req = 1'b0;
            acked = 1'b0;
            ticks_left = '0;
            awaiting_query = 1'b0;
          end
        end
        if (!done && standby_req) begin
          standby_req = 1'b0;
          r.enter_standby = 1'b1;
        end
      end
      CMD_SUSPEND_REQ: begin
        acked = 1'b0;
        user_req = 1'b1;
      end
      CMD_STANDBY_REQ: standby_req = 1'b1;
      CMD_ACK: begin
        if (ticks_left != 0 || user_req) acked = 1'b1;
      end
      CMD_POP: begin
        if (!listening) begin
          r.status = STATUS_NO_LISTEN;
        end else if (ring_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.event_valid = 1'b1;
          r.event_kind = ring_kind[ring_head];
          r.event_sequence = ring_seq[ring_head];
          r.event_stamp = ring_stamp[ring_head];
          ring_head = (ring_head + 1) % RING;
          ring_count--;
        end
      end
      CMD_CLEAR: begin
        ring_count = 0;
        ring_head = 0;
      end
      default: ;
    endcase
    r.phase = awaiting_query;
    return r;
  endfunction

  function automatic void note_bad(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %0h actual %0h", what, want, got);
  endfunction

  function automatic void check_reply(input result_t got, input result_t want);
    if (got.status !== want.status)
      note_bad("status", 32'(want.status), 32'(got.status));
    if (got.event_valid !== want.event_valid)
      note_bad("event_valid", 32'(want.event_valid), 32'(got.event_valid));
    if (got.event_kind !== want.event_kind)
      note_bad("event_kind", 32'(want.event_kind), 32'(got.event_kind));
    if (got.event_sequence !== want.event_sequence)
      note_bad("event_sequence", want.event_sequence, got.event_sequence);
    if (got.event_stamp !== want.event_stamp)
      note_bad("event_stamp", want.event_stamp, got.event_stamp);
    if (got.enter_suspend !== want.enter_suspend)
      note_bad("enter_suspend", 32'(want.enter_suspend), 32'(got.enter_suspend));
    if (got.enter_standby !== want.enter_standby)
      note_bad("enter_standby", 32'(want.enter_standby), 32'(got.enter_standby));
    if (got.signal_listener !== want.signal_listener)
      note_bad("signal_listener", 32'(want.signal_listener),
               32'(got.signal_listener));
    if (got.phase !== want.phase)
      note_bad("phase", 32'(want.phase), 32'(got.phase));
  endfunction

  // command side
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      ctl_replies.push_back(apply_ctl_cmd(cmd_backlog.pop_front()));
      in_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && in_taken == in_marked)) begin
      in_marked = in_taken;
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 9);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser <= cmd_backlog[0].cmd;
        s_tdata <= {{(IN_DATA_W-35){1'b0}}, cmd_backlog[0].qref, cmd_backlog[0].nref,
                    cmd_backlog[0].now, cmd_backlog[0].power};
      end
    end
  end

  // reply side
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      replies_seen++;
      if (ctl_replies.size() == 0) note_bad("unexpected transaction", 32'd0, 32'd1);
      else check_reply(result_t'(m_tdata[RES_W-1:0]), ctl_replies.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!long_hold_done && replies_seen >= 300) begin
      long_hold_done = 1'b1;
      stall_left = 79;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic pwr = 1'b0,
                           input logic [31:0] now = '0, input logic nref = 1'b0,
                           input logic qref = 1'b0);
    ctl_cmd_t c;
    c.cmd = cmd;
    c.power = pwr;
    c.now = now;
    c.nref = nref;
    c.qref = qref;
    cmd_backlog.push_back(c);
    if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) queued++;
  endtask

  function automatic logic [31:0] stamp_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_tick(input logic pwr);
    queue_cmd(CMD_TICK, pwr, stamp_value(), $urandom_range(0, 4) == 0,
              $urandom_range(0, 4) == 0);
  endtask

  task automatic queue_episode();
    int n_ticks;
    int ack_at;
    n_ticks = $urandom_range(1, 8);
    ack_at = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, n_ticks - 1);
    if ($urandom_range(0, 1)) queue_cmd(CMD_SUSPEND_REQ);
    else queue_tick(1'b1);
    for (int i = 0; i < n_ticks; i++) begin
      if (i == ack_at) queue_cmd(CMD_ACK);
      queue_tick($urandom_range(0, 7) == 0);
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_cmd(CMD_STANDBY_REQ);
      queue_tick(1'b0);
    end
    if ($urandom_range(0, 9) == 0) queue_cmd(CMD_CLEAR);
    repeat ($urandom_range(0, 5)) queue_cmd(CMD_POP);
  endtask

  task automatic queue_noise();
    queue_cmd(CMD_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom(),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic fill_phase(input int n_items);
    int start;
    start = queued;
    while (queued - start < n_items) begin
      if ($urandom_range(0, 4) == 0) queue_noise();
      else queue_episode();
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (cmd_backlog.size() != 0 || ctl_replies.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_COUNTDOWN) cd_reload = val[7:0];
    else listening = val[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int cds [7];
    bit lis [7];
    cds = '{1, 255, 2, -1, 0, -1, 3};
    lis = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: no listener, countdown of five
    queue_cmd(CMD_POP);
    queue_cmd(CMD_TICK, 1'b1, 32'h0);
    queue_cmd(CMD_ACK);
    queue_cmd(CMD_TICK, 1'b0, 32'h1, 1'b1, 1'b0);
    queue_cmd(CMD_TICK, 1'b0, 32'h2, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, 1'b0, 32'h3);
    queue_cmd(CMD_SPARE_LO, 1'b1, '1, 1'b1, 1'b1);
    queue_cmd(CMD_SPARE_HI, 1'b1, '1, 1'b1, 1'b1);
    queue_cmd(CMD_CLEAR);
    wait_idle();
    write_reg(REG_COUNTDOWN, 32'd0);
    write_reg(REG_LISTENER, 32'd1);

    // immediate suspend, two events per tick, ring overwrite
    queue_cmd(CMD_POP);
    queue_cmd(CMD_STANDBY_REQ);
    queue_cmd(CMD_TICK, 1'b1, 32'hFFFF_FFFF);
    queue_cmd(CMD_SUSPEND_REQ);
    queue_cmd(CMD_TICK, 1'b0, 32'h0);
    queue_cmd(CMD_ACK);
    queue_cmd(CMD_SUSPEND_REQ);
    queue_cmd(CMD_TICK, 1'b0, 32'hA5A5_5A5A);
    repeat (5) queue_cmd(CMD_POP);
    queue_cmd(CMD_TICK, 1'b1, 32'h1234_5678, 1'b1, 1'b0);
    queue_cmd(CMD_TICK, 1'b1, 32'h8000_0000, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, 1'b0, 32'h7FFF_FFFF);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_POP);
    queue_cmd(CMD_CLEAR);
    queue_cmd(CMD_POP);

    for (int i = 0; i < 7; i++) begin
      wait_idle();
      write_reg(REG_COUNTDOWN, (cds[i] < 0) ? $urandom_range(3, 254) : cds[i]);
      write_reg(REG_LISTENER, 32'(lis[i]));
      if (i == 6) begin
        @(posedge clk);
        idle_on = 1'b0;
      end
      if (cds[i] == 255) begin
        queue_cmd(CMD_SUSPEND_REQ);
        repeat (257) queue_cmd(CMD_TICK, 1'b0, stamp_value());
        repeat (3) queue_cmd(CMD_POP);
      end
      fill_phase(215);
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && ctl_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
